/* src/bmp_to_rgba_stream_decoder_defines.svh */
// Assertion macros shared by the BMP decoder RTL.
`ifndef BMP_TO_RGBA_STREAM_DECODER_DEFINES_SVH
`define BMP_TO_RGBA_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, checked on clk_i, disabled while rst_ni is low.
`define BMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, disabled while rst_ni is low.
`define BMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bmp_pkg.sv */
// Package with constants and controller/datapath types of the BMP decoder.
`default_nettype none
package bmp_pkg;

  localparam int unsigned HdrSize = 54;

  localparam logic [15:0] HDR_LAST    = 16'd53;
  localparam logic [15:0] HDR_SIZE16  = 16'd54;
  localparam logic [15:0] POS_MAGIC_B = 16'd0;
  localparam logic [15:0] POS_MAGIC_M = 16'd1;
  localparam logic [15:0] POS_OFF_LO  = 16'd10;
  localparam logic [15:0] POS_OFF_HI  = 16'd11;
  localparam logic [15:0] POS_WID_LO  = 16'd18;
  localparam logic [15:0] POS_WID_HI  = 16'd19;
  localparam logic [15:0] POS_HGT_LO  = 16'd22;
  localparam logic [15:0] POS_HGT_HI  = 16'd23;
  localparam logic [15:0] POS_DEPTH   = 16'd28;
  localparam logic [15:0] POS_SCAN    = 16'd29;
  localparam logic [15:0] POS_PROD    = 16'd30;
  localparam logic [15:0] POS_NEED    = 16'd31;

  localparam logic [7:0] CHAR_B       = 8'h42;
  localparam logic [7:0] CHAR_M       = 8'h4D;
  localparam logic [7:0] DEPTH_24     = 8'd24;
  localparam logic [7:0] DEPTH_32     = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOT_BMP = 2'd1;
  localparam logic [1:0] STAT_CORRUPT = 2'd2;
  localparam logic [1:0] STAT_DEPTH   = 2'd3;

  // Commands from the controller to the datapath, valid for one accepted byte.
  typedef struct packed {
    logic        hdr_step;
    logic        pix_init;
    logic        pix_step;
    logic [15:0] pos;
    logic        report;
    logic [1:0]  kind;
    logic [1:0]  status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic magic_b;
    logic magic_m;
    logic depth_ok;
    logic hdr_short;
    logic off_small;
    logic file_short;
    logic empty_img;
    logic off_is_hdr;
    logic gap_last;
    logic line_end;
    logic last_line;
  } sts_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] column;
    logic [15:0] row;
    logic [15:0] width;
    logic [15:0] height;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

/* src/bmp_if.sv */
// Stream interfaces of the BMP decoder: file bytes, results and configuration.
`default_nettype none
interface bmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface bmp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [15:0] column;
  logic [15:0] row;
  logic [15:0] width;
  logic [15:0] height;
  logic        last;
  modport source (output valid, output kind, output status, output red, output green,
                  output blue, output alpha, output column, output row, output width,
                  output height, output last, input ready);
  modport sink (input valid, input kind, input status, input red, input green,
                input blue, input alpha, input column, input row, input width,
                input height, input last, output ready);
endinterface

interface bmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/bmp_to_rgba_stream_decoder.sv */
// Top level of the BMP to RGBA stream decoder with its result register.
`default_nettype none
`include "bmp_to_rgba_stream_decoder_defines.svh"
// The decoder takes one file byte per clock cycle and gives at most one result per
// byte: an error report, a header report with the image size, or an RGBA pixel with
// its column and flipped row. Each byte is handled in the cycle it is accepted by a
// single parse step in the controller and datapath; the scanline product and the
// file size bound are worked out while header bytes 29 to 31 pass, so the header
// check is ready at byte 53. Results go through one output register, and a new byte is
// taken whenever that register is empty or is being emptied in the same cycle, so the
// byte stream stalls only while a result waits. The file length register must be
// written before byte one of a file arrives.
module bmp_to_rgba_stream_decoder (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bmp_byte_if.sink  byte_i,
  bmp_cfg_if.sink   cfg_i,
  bmp_res_if.source res_o
);
  import bmp_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;
  logic accept;
  logic out_valid_q, out_valid_d;
  res_t out_q;

  assign cfg_i.ready  = 1'b1;
  assign byte_i.ready = !out_valid_q || res_o.ready;
  assign accept       = byte_i.valid && byte_i.ready;

  bmp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .first_i  (byte_i.first_byte),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  bmp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid && cfg_i.ready),
    .cfg_data_i  (cfg_i.data),
    .data_byte_i (byte_i.data_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (res.valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_q <= res;
    end
  end

  assign res_o.valid  = out_valid_q;
  assign res_o.kind   = out_q.kind;
  assign res_o.status = out_q.status;
  assign res_o.red    = out_q.red;
  assign res_o.green  = out_q.green;
  assign res_o.blue   = out_q.blue;
  assign res_o.alpha  = out_q.alpha;
  assign res_o.column = out_q.column;
  assign res_o.row    = out_q.row;
  assign res_o.width  = out_q.width;
  assign res_o.height = out_q.height;
  assign res_o.last   = out_q.last;

  `BMP_ASSERT_NOW(a_result_only_on_accept, res.valid, accept, "result without request")
  `BMP_ASSERT_NEXT(a_result_registered, res.valid, res_o.valid, "result was dropped")
  `BMP_ASSERT_NOW(a_size_only_in_header, res_o.valid && res_o.kind != KIND_HEADER,
                  res_o.width == '0 && res_o.height == '0, "size outside header result")
  `BMP_ASSERT_NOW(a_pixel_status_ok, res_o.valid && res_o.kind == KIND_PIXEL,
                  res_o.status == STAT_OK, "pixel result with error status")

endmodule
`default_nettype wire

/* src/bmp_ctrl.sv */
// Parse controller of the BMP decoder: phase, byte position and commands.
`default_nettype none
module bmp_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic         first_i,
  input  bmp_pkg::sts_t     sts_i,
  output bmp_pkg::cmd_t     cmd_o
);
  import bmp_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_GAP    = 3'd2;
  localparam logic [2:0] PH_PIX    = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [2:0]  phase_eff;
  logic [15:0] pos_eff;

  // A first byte restarts the parse at header byte zero.
  assign phase_eff = first_i ? PH_HEADER : phase_q;
  assign pos_eff   = first_i ? '0 : pos_q;

  always_comb begin
    phase_d        = phase_q;
    pos_d          = pos_q;
    cmd_o          = '0;
    cmd_o.pos      = pos_eff;
    if (accept_i) begin
      unique case (phase_eff)
        PH_HEADER: begin
          cmd_o.hdr_step = 1'b1;
          phase_d        = PH_HEADER;
          pos_d          = pos_eff + 16'd1;
          if (pos_eff == POS_MAGIC_B && !sts_i.magic_b) begin
            cmd_o.report = 1'b1;
            cmd_o.kind   = KIND_ERROR;
            cmd_o.status = STAT_NOT_BMP;
          end else if (pos_eff == POS_MAGIC_M && !sts_i.magic_m) begin
            cmd_o.report = 1'b1;
            cmd_o.kind   = KIND_ERROR;
            cmd_o.status = STAT_NOT_BMP;
          end else if (pos_eff == POS_MAGIC_M && sts_i.hdr_short) begin
            cmd_o.report = 1'b1;
            cmd_o.kind   = KIND_ERROR;
            cmd_o.status = STAT_CORRUPT;
          end else if (pos_eff == POS_DEPTH && !sts_i.depth_ok) begin
            cmd_o.report = 1'b1;
            cmd_o.kind   = KIND_ERROR;
            cmd_o.status = STAT_DEPTH;
          end else if (pos_eff == HDR_LAST) begin
            cmd_o.report = 1'b1;
            if (sts_i.off_small || sts_i.file_short) begin
              cmd_o.kind   = KIND_ERROR;
              cmd_o.status = STAT_CORRUPT;
            end else begin
              cmd_o.kind     = KIND_HEADER;
              cmd_o.status   = STAT_OK;
              cmd_o.pix_init = 1'b1;
              priority if (sts_i.empty_img) begin
                phase_d = PH_DONE;
              end else if (sts_i.off_is_hdr) begin
                phase_d = PH_PIX;
              end else begin
                phase_d = PH_GAP;
              end
            end
          end
          if (cmd_o.report && cmd_o.kind == KIND_ERROR) begin
            phase_d = PH_IDLE;
          end
        end
        PH_GAP: begin
          pos_d = pos_q + 16'd1;
          if (sts_i.gap_last) begin
            phase_d = PH_PIX;
          end
        end
        PH_PIX: begin
          cmd_o.pix_step = 1'b1;
          if (sts_i.line_end && sts_i.last_line) begin
            phase_d = PH_DONE;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

endmodule
`default_nettype wire

/* src/bmp_dp.sv */
// Datapath of the BMP decoder: header fields, size check and pixel assembly.
`default_nettype none
module bmp_dp (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic [7:0]   data_byte_i,
  input  bmp_pkg::cmd_t     cmd_i,
  output bmp_pkg::sts_t     sts_o,
  output bmp_pkg::res_t     res_o
);
  import bmp_pkg::*;

  logic [31:0] file_len_q;
  logic [15:0] offset_q;
  logic [15:0] width_q;
  logic [15:0] height_q;
  logic        four_ch_q;
  logic [17:0] scan_q;
  logic [17:0] pxb_q;
  logic [33:0] prod_q;
  logic [34:0] need_q;
  logic [17:0] lbc_q;
  logic [1:0]  sub_q;
  logic [15:0] col_q;
  logic [15:0] row_q;
  logic [23:0] pix_q;

  logic [17:0] wch;
  logic [17:0] scan_c;
  logic        in_px;
  logic        emit;
  logic [1:0]  sub_last;

  // Bytes per line without padding, then rounded up to a multiple of four.
  assign wch    = four_ch_q ? {width_q, 2'b00}
                            : ({1'b0, width_q, 1'b0} + {2'b00, width_q});
  assign scan_c = (wch + 18'd3) & ~18'd3;

  assign sub_last = four_ch_q ? 2'd3 : 2'd2;
  assign in_px    = (lbc_q < pxb_q);
  assign emit     = cmd_i.pix_step && in_px && (sub_q == sub_last);

  always_comb begin
    sts_o            = '0;
    sts_o.magic_b    = (data_byte_i == CHAR_B);
    sts_o.magic_m    = (data_byte_i == CHAR_M);
    sts_o.depth_ok   = (data_byte_i == DEPTH_24) || (data_byte_i == DEPTH_32);
    sts_o.hdr_short  = (file_len_q < HdrSize);
    sts_o.off_small  = (offset_q < HDR_SIZE16);
    sts_o.file_short = ({3'b000, file_len_q} < need_q);
    sts_o.empty_img  = (width_q == '0) || (height_q == '0);
    sts_o.off_is_hdr = (offset_q == HDR_SIZE16);
    sts_o.gap_last   = (({1'b0, cmd_i.pos} + 17'd1) == {1'b0, offset_q});
    sts_o.line_end   = (({1'b0, lbc_q} + 19'd1) == {1'b0, scan_q});
    sts_o.last_line  = (row_q == '0);
  end

  always_comb begin
    res_o = '0;
    if (cmd_i.report) begin
      res_o.valid  = 1'b1;
      res_o.kind   = cmd_i.kind;
      res_o.status = cmd_i.status;
      if (cmd_i.kind == KIND_HEADER) begin
        res_o.width  = width_q;
        res_o.height = height_q;
      end
    end else if (emit) begin
      res_o.valid  = 1'b1;
      res_o.kind   = KIND_PIXEL;
      res_o.status = STAT_OK;
      // In 24-bit files the red byte is the one arriving now.
      res_o.red    = four_ch_q ? pix_q[23:16] : data_byte_i;
      res_o.green  = pix_q[15:8];
      res_o.blue   = pix_q[7:0];
      res_o.alpha  = four_ch_q ? data_byte_i : ALPHA_OPAQUE;
      res_o.column = col_q;
      res_o.row    = row_q;
      res_o.last   = (row_q == '0) && (col_q == width_q - 16'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_len_q <= '0;
    end else if (cfg_we_i) begin
      file_len_q <= cfg_data_i;
    end
  end

  // Header capture; the size check is spread over the bytes after the depth field.
  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_step) begin
      unique case (cmd_i.pos)
        POS_OFF_LO: offset_q  <= {8'h00, data_byte_i};
        POS_OFF_HI: offset_q  <= {data_byte_i, offset_q[7:0]};
        POS_WID_LO: width_q   <= {8'h00, data_byte_i};
        POS_WID_HI: width_q   <= {data_byte_i, width_q[7:0]};
        POS_HGT_LO: height_q  <= {8'h00, data_byte_i};
        POS_HGT_HI: height_q  <= {data_byte_i, height_q[7:0]};
        POS_DEPTH:  four_ch_q <= (data_byte_i == DEPTH_32);
        POS_SCAN: begin
          scan_q <= scan_c;
          pxb_q  <= wch;
        end
        POS_PROD:   prod_q    <= scan_q * height_q;
        POS_NEED:   need_q    <= {1'b0, prod_q} + {19'd0, offset_q};
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_init) begin
      lbc_q <= '0;
      sub_q <= '0;
      col_q <= '0;
      row_q <= height_q - 16'd1;
    end else if (cmd_i.pix_step) begin
      if (in_px) begin
        unique case (sub_q)
          2'd0:    pix_q[7:0]   <= data_byte_i;
          2'd1:    pix_q[15:8]  <= data_byte_i;
          2'd2:    pix_q[23:16] <= data_byte_i;
          default: pix_q        <= pix_q;
        endcase
      end
      if (sts_o.line_end) begin
        lbc_q <= '0;
        sub_q <= '0;
        col_q <= '0;
        row_q <= row_q - 16'd1;
      end else begin
        lbc_q <= lbc_q + 18'd1;
        if (emit) begin
          sub_q <= '0;
          col_q <= col_q + 16'd1;
        end else if (in_px) begin
          sub_q <= sub_q + 2'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire
